[rtl/assert_macros.svh]
// assertion helpers, sampled on clk and switched off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sobel_pkg.sv]
package sobel_pkg;

    localparam int MAX_WIDTH_DEF = 8192;
    localparam int ROW_LIMIT     = 8192;
    localparam int REG_W         = 14;
    localparam int COORD_W       = 13;
    localparam int PIX_W         = 8;
    localparam int SUM_W         = PIX_W + 2;
    localparam int GRAD_W        = SUM_W + 1;
    localparam int SQ_W          = 2 * SUM_W;
    localparam int SSUM_W        = SQ_W + 1;
    localparam int ROOT_IN_W     = 2 * PIX_W;
    localparam int BIT_W         = $clog2(PIX_W);
    localparam int CFG_IDX_W     = 1;
    localparam int NUM_KINDS     = 4;

    localparam logic [REG_W-1:0]  WIDTH_RESET  = 14'd7112;
    localparam logic [REG_W-1:0]  HEIGHT_RESET = 14'd5146;
    localparam logic [PIX_W-1:0]  MAG_MAX      = 8'd255;
    localparam logic [SSUM_W-1:0] SAT_SQ       = 21'd65025;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_ROOT,
        ST_EMIT
    } state_t;

endpackage

[rtl/sobel_pix_if.sv]
interface sobel_pix_if import sobel_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

[rtl/sobel_cfg_if.sv]
interface sobel_cfg_if import sobel_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/sobel_res_if.sv]
interface sobel_res_if import sobel_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [PIX_W-1:0]   magnitude;
    logic               last_of_run;
    logic               frame_done;

    modport source (
        output valid, output out_col, output out_row, output magnitude,
        output last_of_run, output frame_done, input ready
    );
    modport sink (
        input valid, input out_col, input out_row, input magnitude,
        input last_of_run, input frame_done, output ready
    );
endinterface

[rtl/sobel_ram.sv]
module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/sobel_edge_magnitude_stream_core.sv]
// channel  dir  payload                                        handshake
// pix      in   pixel[7:0]                                     valid / ready
// cfg      in   index[0], data[13:0]  (0 width, 1 height)      valid / ready (always ready)
// res      out  out_col, out_row, magnitude, last_of_run,      valid / ready
//               frame_done
//
// one pixel request is worked at a time; ready is high only while idle
// a pixel with no result goes back to idle after its line store read; border results
// go straight to emission, and an interior magnitude first has its squares summed,
// then runs the 8-step square root loop unless the square sum saturates
// each result waits in the output register while res.ready stays low
// reset: counters at frame origin, window zero, registers at defaults; line store unset
module sobel_edge_magnitude_stream_core import sobel_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sobel_pix_if.sink  pix,
    sobel_cfg_if.sink  cfg,
    sobel_res_if.source res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = 2 * PIX_W;

    // control
    state_t state_reg, state_next;
    logic   accept;
    logic   ram_re;
    logic   ram_we;
    logic   load_out;
    logic   emit_free;
    logic   res_fire;

    // configuration registers
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;

    // position of the next pixel
    logic [CW-1:0]      col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;

    // per-request context
    logic [CW-1:0]        c_reg;
    logic [COORD_W-1:0]   r_reg;
    logic [PIX_W-1:0]     px_reg;
    logic [NUM_KINDS-1:0] pend_reg, pend_next;
    logic                 interior_reg;

    // window: left column (c-2) and middle column (c-1), top to bottom
    logic [PIX_W-1:0] wl_reg [3];
    logic [PIX_W-1:0] wm_reg [3];

    // gradient and square root
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [ROOT_IN_W-1:0]     s_reg;
    logic [PIX_W-1:0]         root_reg;
    logic [BIT_W-1:0]         bit_reg;
    logic [PIX_W-1:0]         mag_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [PIX_W-1:0]   out_mag_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    // ------------------------------------------------------------------
    // frame geometry, clamped to what the hardware supports
    // ------------------------------------------------------------------
    logic [31:0]        wr32, hr32;
    logic [CW-1:0]      w_m1;
    logic [COORD_W-1:0] h_m1;
    logic [CW-1:0]      c_cur;
    logic [COORD_W-1:0] r_cur;
    logic               at_right, at_bottom;

    always_comb
    begin
        wr32 = 32'(width_reg);
        hr32 = 32'(height_reg);
        if (wr32 < 32'd3)
        begin
            w_m1 = CW'(2);
        end
        else if (wr32 > 32'(MAX_WIDTH))
        begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = CW'(wr32 - 32'd1);
        end
        if (hr32 < 32'd3)
        begin
            h_m1 = COORD_W'(2);
        end
        else if (hr32 > 32'(ROW_LIMIT))
        begin
            h_m1 = COORD_W'(ROW_LIMIT - 1);
        end
        else
        begin
            h_m1 = COORD_W'(hr32 - 32'd1);
        end
        // counters left beyond the frame by a register change saturate at the edge
        c_cur     = (col_reg > w_m1) ? w_m1 : col_reg;
        r_cur     = (row_reg > h_m1) ? h_m1 : row_reg;
        at_right  = (c_cur == w_m1);
        at_bottom = (r_cur == h_m1);
        if (at_right)
        begin
            col_next = '0;
            row_next = at_bottom ? '0 : r_cur + COORD_W'(1);
        end
        else
        begin
            col_next = c_cur + CW'(1);
            row_next = r_cur;
        end
        // results in emission order:
        // bit 0 centre (c-1, r-1), bit 1 right edge (c, r-1),
        // bit 2 bottom row (c-1, r), bit 3 bottom-right corner (c, r)
        pend_next[0] = (r_cur != '0) && (c_cur != '0);
        pend_next[1] = (r_cur != '0) && at_right;
        pend_next[2] = at_bottom && (c_cur != '0);
        pend_next[3] = at_bottom && at_right;
    end

    // ------------------------------------------------------------------
    // line store: one word per column holding {row r-2, row r-1}
    // read at acceptance, written back the next cycle, so a later read of the
    // same column always sees the update and needs no forwarding
    // ------------------------------------------------------------------
    logic [LW-1:0] ram_rdata;
    logic [LW-1:0] ram_wdata;

    sobel_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    // right window column: upper line, lower line, new pixel
    logic [PIX_W-1:0] cur [3];

    assign cur[0]    = ram_rdata[LW-1:PIX_W];
    assign cur[1]    = ram_rdata[PIX_W-1:0];
    assign cur[2]    = px_reg;
    assign ram_wdata = {cur[1], px_reg};

    // ------------------------------------------------------------------
    // sobel sums
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]         sum_l, sum_r, sum_t, sum_b;
    logic signed [GRAD_W-1:0] gx_comb, gy_comb;

    always_comb
    begin
        sum_l   = SUM_W'(wl_reg[0]) + SUM_W'({wl_reg[1], 1'b0}) + SUM_W'(wl_reg[2]);
        sum_r   = SUM_W'(cur[0]) + SUM_W'({cur[1], 1'b0}) + SUM_W'(cur[2]);
        sum_t   = SUM_W'(wl_reg[0]) + SUM_W'({wm_reg[0], 1'b0}) + SUM_W'(cur[0]);
        sum_b   = SUM_W'(wl_reg[2]) + SUM_W'({wm_reg[2], 1'b0}) + SUM_W'(cur[2]);
        gx_comb = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        gy_comb = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    end

    // squares, taken in the cycle after the sums
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [SSUM_W-1:0]          s_full;

    always_comb
    begin
        gx_sq  = gx_reg * gx_reg;
        gy_sq  = gy_reg * gy_reg;
        s_full = SSUM_W'(gx_sq[SQ_W-1:0]) + SSUM_W'(gy_sq[SQ_W-1:0]);
    end

    // one result bit per cycle: keep the trial bit when its square still fits
    logic [PIX_W-1:0]     trial;
    logic [ROOT_IN_W-1:0] trial_sq;
    logic [PIX_W-1:0]     root_step;

    always_comb
    begin
        trial     = root_reg | (PIX_W'(1) << bit_reg);
        trial_sq  = ROOT_IN_W'(trial) * ROOT_IN_W'(trial);
        root_step = (trial_sq <= s_reg) ? trial : root_reg;
    end

    // ------------------------------------------------------------------
    // result selection: lowest pending kind goes next
    // ------------------------------------------------------------------
    logic [NUM_KINDS-1:0] pend_left;
    logic [COORD_W-1:0]   sel_col, sel_row;
    logic [PIX_W-1:0]     sel_mag;
    logic                 sel_done;
    logic [31:0]          c_ext, cm1_ext;

    always_comb
    begin
        c_ext     = 32'(c_reg);
        cm1_ext   = c_ext - 32'd1;
        pend_left = pend_reg;
        sel_col   = c_ext[COORD_W-1:0];
        sel_row   = r_reg;
        sel_mag   = '0;
        sel_done  = 1'b0;
        if (pend_reg[0])
        begin
            pend_left[0] = 1'b0;
            sel_col      = cm1_ext[COORD_W-1:0];
            sel_row      = r_reg - COORD_W'(1);
            sel_mag      = mag_reg;
        end
        else if (pend_reg[1])
        begin
            pend_left[1] = 1'b0;
            sel_row      = r_reg - COORD_W'(1);
        end
        else if (pend_reg[2])
        begin
            pend_left[2] = 1'b0;
            sel_col      = cm1_ext[COORD_W-1:0];
        end
        else
        begin
            pend_left[3] = 1'b0;
            sel_done     = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign res_fire  = out_valid_reg && res.ready;
    assign emit_free = !out_valid_reg || res_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pix.ready  = 1'b0;
        accept     = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pix.ready = 1'b1;
                accept    = pix.valid;
                ram_re    = pix.valid;
                if (pix.valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_we = 1'b1;
                if (pend_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (interior_reg)
                begin
                    state_next = ST_SQUARE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SQUARE:
            begin
                if (s_full >= SAT_SQ)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_free)
                begin
                    if (pend_reg != '0)
                    begin
                        load_out = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration, position counters and pending results
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                wl_reg[i] <= '0;
                wm_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_WIDTH:  width_reg  <= cfg.data;
                    CFG_HEIGHT: height_reg <= cfg.data;
                    default:    ;
                endcase
            end
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                pend_reg <= pend_next;
            end
            else if (load_out)
            begin
                pend_reg <= pend_left;
            end
            if (ram_we)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    wl_reg[i] <= wm_reg[i];
                    wm_reg[i] <= cur[i];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c_reg        <= c_cur;
            r_reg        <= r_cur;
            px_reg       <= pix.pixel;
            // interior: not the first two columns or rows; the bottom row is
            // never a centre here
            interior_reg <= (c_cur >= CW'(2)) && (r_cur >= COORD_W'(2));
        end
        if (ram_we)
        begin
            gx_reg  <= gx_comb;
            gy_reg  <= gy_comb;
            mag_reg <= '0;
        end
        if (state_reg == ST_SQUARE)
        begin
            s_reg    <= s_full[ROOT_IN_W-1:0];
            root_reg <= '0;
            bit_reg  <= BIT_W'(PIX_W - 1);
            if (s_full >= SAT_SQ)
            begin
                mag_reg <= MAG_MAX;
            end
        end
        if (state_reg == ST_ROOT)
        begin
            root_reg <= root_step;
            bit_reg  <= bit_reg - BIT_W'(1);
            if (bit_reg == '0)
            begin
                mag_reg <= root_step;
            end
        end
        if (load_out)
        begin
            out_col_reg  <= sel_col;
            out_row_reg  <= sel_row;
            out_mag_reg  <= sel_mag;
            out_last_reg <= (pend_left == '0);
            out_done_reg <= sel_done;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_col     = out_col_reg;
    assign res.out_row     = out_row_reg;
    assign res.magnitude   = out_mag_reg;
    assign res.last_of_run = out_last_reg;
    assign res.frame_done  = out_done_reg;

endmodule

[rtl/sobel_checker.sv]
`include "assert_macros.svh"

module sobel_checker import sobel_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               pix_valid,
    input logic               pix_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [COORD_W-1:0] res_out_col,
    input logic [COORD_W-1:0] res_out_row,
    input logic [PIX_W-1:0]   res_magnitude,
    input logic               res_last_of_run,
    input logic               res_frame_done
);

    // a waiting result keeps its contents
    `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_out_col) && $stable(res_out_row) && $stable(res_magnitude) && $stable(res_last_of_run) && $stable(res_frame_done), "result changed while stalled")

    // no new pixel while results of the last one are still out
    `ASSERT_SAME(a_one_at_a_time, res_valid, !pix_ready, "pixel taken while results pending")

    // the corner result closes its run
    `ASSERT_SAME(a_done_is_last, res_valid && res_frame_done, res_last_of_run, "frame_done without last_of_run")

    // top row and left column are border pixels
    `ASSERT_SAME(a_border_zero, res_valid && (res_out_row == '0 || res_out_col == '0), res_magnitude == '0, "nonzero border magnitude")

    // a run continues without a gap until its last result
    `ASSERT_NEXT(a_run_gapless, res_valid && res_ready && !res_last_of_run, res_valid, "gap inside a result run")

endmodule

bind sobel_edge_magnitude_stream_core sobel_checker u_sobel_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_valid       (pix.valid),
    .pix_ready       (pix.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_out_col     (res.out_col),
    .res_out_row     (res.out_row),
    .res_magnitude   (res.magnitude),
    .res_last_of_run (res.last_of_run),
    .res_frame_done  (res.frame_done)
);

[test/sobel_edge_magnitude_stream_core_tb.sv]
`timescale 1ns / 1ps

module sobel_edge_magnitude_stream_core_tb;
    import sobel_pkg::*;

    // generous cycle budget: every pixel at its longest run under heavy stalls,
    // plus the long hold-off, several times over
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 90;
    localparam int PRINT_CAP     = 40;

    // receiver behavior, picked per stretch of cycles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    // one expected output pixel
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   mag;
        logic               last_flag;
        logic               done_flag;
    } edge_res_t;

    logic clk;
    logic rst_n;

    sobel_pix_if pix_bus ();
    sobel_cfg_if cfg_bus ();
    sobel_res_if res_bus ();

    sobel_edge_magnitude_stream_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_bus),
        .cfg   (cfg_bus),
        .res   (res_bus)
    );

    // pixel requests waiting to be offered, and output pixels still owed by the block
    logic [PIX_W-1:0] pixel_q [$];
    edge_res_t        pending_edges [$];
    edge_res_t        want_res;
    int               error_count = 0;
    int               cycle_count = 0;

    // shadow of the block: line stores, two 3-pixel window columns, raster position, registers
    logic [PIX_W-1:0] upper_mem [0:MAX_WIDTH_DEF-1];
    logic [PIX_W-1:0] lower_mem [0:MAX_WIDTH_DEF-1];
    logic [PIX_W-1:0] win_px [0:5];
    int unsigned      next_col = 0;
    int unsigned      next_row = 0;
    logic [REG_W-1:0] width_reg  = WIDTH_RESET;
    logic [REG_W-1:0] height_reg = HEIGHT_RESET;

    // sender burst state
    int burst_left = 1;
    int gap_left   = 0;

    // receiver state, including the one long hold-off
    bit       hold_req  = 1'b0;
    bit       hold_used = 1'b0;
    int       hold_left = 0;
    rx_mode_t rx_mode   = RX_OPEN;
    int       mode_left = 0;
    logic [7:0] stall_pattern = 8'b1011_0110;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // registers outside 3..hi are taken at the nearest end
    function automatic int unsigned clamp_dim(logic [REG_W-1:0] val, int unsigned hi);
        if (val < 3)
            return 3;
        if (val > hi)
            return hi;
        return val;
    endfunction

    // floor(sqrt(gx^2 + gy^2)) saturated to 255, built bit by bit
    function automatic logic [PIX_W-1:0] gradient_mag(int l0, int l1, int l2, int m0,
                                                      int m2, int r0, int r1, int r2);
        int          gx;
        int          gy;
        int unsigned sq;
        int unsigned root;
        int unsigned trial;
        gx = (l0 + 2 * l1 + l2) - (r0 + 2 * r1 + r2);
        gy = (l0 + 2 * m0 + r0) - (l2 + 2 * m2 + r2);
        sq = gx * gx + gy * gy;
        if (sq >= SAT_SQ)
            return MAG_MAX;
        root = 0;
        for (int b = PIX_W - 1; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root[PIX_W-1:0];
    endfunction

    function automatic edge_res_t make_res(int unsigned col, int unsigned row,
                                           logic [PIX_W-1:0] mag, logic done);
        edge_res_t item;
        item.col       = col[COORD_W-1:0];
        item.row       = row[COORD_W-1:0];
        item.mag       = mag;
        item.last_flag = 1'b0;
        item.done_flag = done;
        return item;
    endfunction

    // one accepted pixel: queue every output pixel it completes, then advance
    function automatic void predict_edge_pixels(logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        logic [PIX_W-1:0] mag;
        edge_res_t        found [$];
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, ROW_LIMIT);
        // position saturates if a register shrank the frame under the counters
        c = (next_col > w - 1) ? w - 1 : next_col;
        r = (next_row > h - 1) ? h - 1 : next_row;
        top_px = upper_mem[c];
        mid_px = lower_mem[c];

        // center of the completed neighborhood
        if (r >= 1 && c >= 1)
        begin
            mag = '0;
            if (c - 1 != 0 && r - 1 != 0 && r - 1 != h - 1)
                mag = gradient_mag(win_px[0], win_px[1], win_px[2], win_px[3], win_px[5],
                                   top_px, mid_px, px);
            found.push_back(make_res(c - 1, r - 1, mag, 1'b0));
        end
        // right border of the row above
        if (r >= 1 && c == w - 1)
            found.push_back(make_res(w - 1, r - 1, '0, 1'b0));
        // bottom row zeros go out along with the row above
        if (r == h - 1 && c >= 1)
            found.push_back(make_res(c - 1, r, '0, 1'b0));
        // bottom-right corner closes the frame
        if (r == h - 1 && c == w - 1)
            found.push_back(make_res(w - 1, r, '0, 1'b1));
        if (found.size() != 0)
            found[found.size() - 1].last_flag = 1'b1;
        foreach (found[i])
            pending_edges.push_back(found[i]);

        // shift the window one column left and update the line stores
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = top_px;
        win_px[4] = mid_px;
        win_px[5] = px;
        upper_mem[c] = mid_px;
        lower_mem[c] = px;

        if (c == w - 1)
        begin
            next_col = 0;
            next_row = (r == h - 1) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // biased toward the extremes so saturation and flat areas show up
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MAG_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixels(int count);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(pick_pixel());
    endtask

    // register write request, only issued while the block is idle
    task automatic write_reg(cfg_reg_t idx, logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // every pixel taken, every output pixel seen, plus slack for a pixel with no output
    task automatic wait_drained();
        @(negedge clk);
        while (pixel_q.size() != 0 || pix_bus.valid || pending_edges.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // pixel driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_bus.valid && pix_bus.ready)
                predict_edge_pixels(pix_bus.pixel);
            // a request is held until taken
            if (!pix_bus.valid || pix_bus.ready)
            begin
                if (gap_left != 0 || pixel_q.size() == 0)
                begin
                    pix_bus.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
                else
                begin
                    pix_bus.valid <= 1'b1;
                    pix_bus.pixel <= pixel_q.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        // a quarter of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: stretches of open, random and patterned stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else if (hold_req && !hold_used)
        begin
            // long hold-off so the block backs up and stalls its input
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            res_bus.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            case (rx_mode)
                RX_OPEN:
                    res_bus.ready <= 1'b1;
                RX_RANDOM:
                    res_bus.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
                    res_bus.ready <= stall_pattern[0];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: check each taken result against the oldest expectation,
    // and track register writes in the shadow
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_edges.size() == 0)
            begin
                error_count++;
                if (error_count <= PRINT_CAP)
                    $display("%0t: unexpected result col %0d row %0d mag %0d last %0b done %0b",
                             $realtime, res_bus.out_col, res_bus.out_row, res_bus.magnitude,
                             res_bus.last_of_run, res_bus.frame_done);
            end
            else
            begin
                want_res = pending_edges.pop_front();
                if (res_bus.out_col !== want_res.col || res_bus.out_row !== want_res.row ||
                    res_bus.magnitude !== want_res.mag ||
                    res_bus.last_of_run !== want_res.last_flag ||
                    res_bus.frame_done !== want_res.done_flag)
                begin
                    error_count++;
                    if (error_count <= PRINT_CAP)
                        $display({"%0t: mismatch expected col %0d row %0d mag %0d last %0b ",
                                  "done %0b, actual col %0d row %0d mag %0d last %0b done %0b"},
                                 $realtime, want_res.col, want_res.row, want_res.mag,
                                 want_res.last_flag, want_res.done_flag, res_bus.out_col,
                                 res_bus.out_row, res_bus.magnitude, res_bus.last_of_run,
                                 res_bus.frame_done);
                end
            end
        end
        if (rst_n && cfg_bus.valid && cfg_bus.ready)
        begin
            case (cfg_bus.index)
                CFG_WIDTH:  width_reg  = cfg_bus.data;
                CFG_HEIGHT: height_reg = cfg_bus.data;
                default: ;
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          random_count;
        int          frame_len;

        rst_n         = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_WIDTH;
        cfg_bus.data  = '0;
        res_bus.ready = 1'b0;
        foreach (upper_mem[i])
        begin
            upper_mem[i] = '0;
            lower_mem[i] = '0;
        end
        foreach (win_px[i])
            win_px[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // smallest frame from zero registers (both taken as 3); a hard
        // vertical edge drives the magnitude into saturation
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, '0);
        @(negedge clk);
        for (int i = 0; i < 3; i++)
        begin
            pixel_q.push_back(MAG_MAX);
            pixel_q.push_back(8'd128);
            pixel_q.push_back('0);
        end
        wait_drained();

        // 4x3 ramp: moderate gradients well below saturation
        write_reg(CFG_WIDTH, REG_W'(4));
        write_reg(CFG_HEIGHT, REG_W'(3));
        @(negedge clk);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 4; x++)
                pixel_q.push_back(PIX_W'(10 * (x + 1) + 5 * y));
        wait_drained();

        // widest and tallest settings: both registers above range, clamped to
        // the line store size and the row limit; part of the first row only
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, '1);
        @(negedge clk);
        queue_pixels(20);
        wait_drained();

        // shrink the width in mid-row so the column counter saturates, run a
        // few rows, then shrink both registers so both counters saturate
        write_reg(CFG_WIDTH, REG_W'(8));
        @(negedge clk);
        queue_pixels(1 + 8 * 4 + 6);
        wait_drained();
        write_reg(CFG_WIDTH, REG_W'(5));
        write_reg(CFG_HEIGHT, REG_W'(4));
        @(negedge clk);
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, ROW_LIMIT);
        c = (next_col > w - 1) ? w - 1 : next_col;
        r = (next_row > h - 1) ? h - 1 : next_row;
        queue_pixels((h - 1 - r) * w + (w - c));
        wait_drained();

        // random frames of small sizes; the receiver holds off once at the start
        hold_req     = 1'b1;
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            // new size most of the time; otherwise frames run back to back
            if ($urandom_range(0, 3) != 0)
            begin
                wait_drained();
                write_reg(CFG_WIDTH, REG_W'($urandom_range(3, 9)));
                write_reg(CFG_HEIGHT, REG_W'($urandom_range(3, 6)));
            end
            @(negedge clk);
            frame_len = clamp_dim(width_reg, MAX_WIDTH_DEF) * clamp_dim(height_reg, ROW_LIMIT);
            queue_pixels(frame_len);
            random_count += frame_len;
        end

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
